[hdl/ssq_pkg.sv]
// shared constants and types for the stable sorted priority queue
`default_nettype none

package ssq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int DATA_W          = 32;
	localparam int STATUS_W        = 2;
	localparam int FILL_W          = 5;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic load;
		logic exec;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_blocked;
	} dp_stat_t;

endpackage

`default_nettype wire

[hdl/stable_sorted_priority_queue_top.sv]
// top level of the stable sorted priority queue
`default_nettype none

// Holds up to QUEUE_DEPTH (value, weight) entries in ascending weight order; an
// enqueue lands after every entry of equal or smaller weight, a dequeue takes the
// head. Every transfer in gives exactly one result transfer out. An item is first
// captured; then every entry cell compares its weight with the key in parallel
// and the entries shift in place, a step that waits while out_stall holds a
// result. The next item is taken in the cycle after that step, so no new item
// is taken before the last one is through.

module stable_sorted_priority_queue_top #(
	parameter int QUEUE_DEPTH = ssq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              opcode,
	input  wire logic signed [ssq_pkg::DATA_W-1:0] item_value,
	input  wire logic signed [ssq_pkg::DATA_W-1:0] item_weight,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [ssq_pkg::STATUS_W-1:0]           status,
	output logic signed [ssq_pkg::DATA_W-1:0]      out_value,
	output logic signed [ssq_pkg::DATA_W-1:0]      out_weight,
	output logic [ssq_pkg::FILL_W-1:0]             fill_count
);
	import ssq_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	ssq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	ssq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.opcode      (opcode),
		.item_value  (item_value),
		.item_weight (item_weight),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.out_value   (out_value),
		.out_weight  (out_weight),
		.fill_count  (fill_count)
	);

endmodule

`default_nettype wire

[hdl/ssq_ctrl.sv]
// controller state machine: capture, then execute when the result register is free
`default_nettype none

module ssq_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output ssq_pkg::ctl_cmd_t    cmd,
	input  wire ssq_pkg::dp_stat_t stat
);
	import ssq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		cmd.load  = 1'b0;
		cmd.exec  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!stat.out_blocked) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[hdl/ssq_datapath.sv]
// datapath: row of sorted entry cells, fill count and result register
`default_nettype none

module ssq_datapath #(
	parameter int QUEUE_DEPTH = ssq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ssq_pkg::ctl_cmd_t                 cmd,
	output ssq_pkg::dp_stat_t                      stat,
	input  wire logic                              opcode,
	input  wire logic signed [ssq_pkg::DATA_W-1:0] item_value,
	input  wire logic signed [ssq_pkg::DATA_W-1:0] item_weight,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [ssq_pkg::STATUS_W-1:0]           status,
	output logic signed [ssq_pkg::DATA_W-1:0]      out_value,
	output logic signed [ssq_pkg::DATA_W-1:0]      out_weight,
	output logic [ssq_pkg::FILL_W-1:0]             fill_count
);
	import ssq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic                     op_q;
	logic signed [DATA_W-1:0] key_val_q;
	logic signed [DATA_W-1:0] key_wgt_q;
	logic signed [DATA_W-1:0] val_q [QUEUE_DEPTH];
	logic signed [DATA_W-1:0] wgt_q [QUEUE_DEPTH];
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_d;
	logic [CW+FILL_W-1:0]     count_ext;
	logic [QUEUE_DEPTH-1:0]   gt;
	logic                     full;
	logic                     empty;
	logic                     do_enq;
	logic                     do_deq;
	logic                     out_valid_q;
	logic [STATUS_W-1:0]      status_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic signed [DATA_W-1:0] out_weight_q;
	logic [FILL_W-1:0]        fill_q;

	assign full   = (count_q == CW'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign do_enq = (op_q == OP_ENQ) && !full;
	assign do_deq = (op_q == OP_DEQ) && !empty;

	always_comb begin
		count_d = count_q;
		if (do_enq) begin
			count_d = count_q + CW'(1);
		end else if (do_deq) begin
			count_d = count_q - CW'(1);
		end
	end

	assign count_ext        = {{FILL_W{1'b0}}, count_d};
	assign stat.out_blocked = out_valid_q && out_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= opcode;
			key_val_q <= item_value;
			key_wgt_q <= item_weight;
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                     prev_gt;
		logic                     at_end;
		logic signed [DATA_W-1:0] prev_val;
		logic signed [DATA_W-1:0] prev_wgt;
		logic signed [DATA_W-1:0] next_val;
		logic signed [DATA_W-1:0] next_wgt;

		assign gt[i]  = (CW'(i) < count_q) && (wgt_q[i] > key_wgt_q);
		assign at_end = (CW'(i) == count_q);

		if (i == 0) begin : g_first
			assign prev_gt  = 1'b0;
			assign prev_val = key_val_q;
			assign prev_wgt = key_wgt_q;
		end else begin : g_rest
			assign prev_gt  = gt[i-1];
			assign prev_val = val_q[i-1];
			assign prev_wgt = wgt_q[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_val = val_q[i];
			assign next_wgt = wgt_q[i];
		end else begin : g_inner
			assign next_val = val_q[i+1];
			assign next_wgt = wgt_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (do_enq) begin
					if (prev_gt) begin
						val_q[i] <= prev_val;
						wgt_q[i] <= prev_wgt;
					end else if (gt[i] || at_end) begin
						val_q[i] <= key_val_q;
						wgt_q[i] <= key_wgt_q;
					end
				end else if (do_deq) begin
					val_q[i] <= next_val;
					wgt_q[i] <= next_wgt;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			fill_q       <= count_ext[FILL_W-1:0];
			out_value_q  <= '0;
			out_weight_q <= '0;
			status_q     <= ST_DONE;
			if (op_q == OP_ENQ) begin
				if (full) begin
					status_q <= ST_FULL;
				end
			end else if (empty) begin
				status_q <= ST_EMPTY;
			end else begin
				out_value_q  <= val_q[0];
				out_weight_q <= wgt_q[0];
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_value  = out_value_q;
	assign out_weight = out_weight_q;
	assign fill_count = fill_q;

endmodule

`default_nettype wire

[hdl/ssq_checker.sv]
// port-level checks for the stable sorted priority queue, bound to the top level
`default_nettype none

module ssq_checker #(
	parameter int QUEUE_DEPTH = ssq_pkg::QUEUE_DEPTH_DEF
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_stall,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic [ssq_pkg::STATUS_W-1:0]      status,
	input wire logic signed [ssq_pkg::DATA_W-1:0] out_value,
	input wire logic signed [ssq_pkg::DATA_W-1:0] out_weight,
	input wire logic [ssq_pkg::FILL_W-1:0]        fill_count
);
	import ssq_pkg::*;

	localparam int FW = FILL_W + 10;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("new transfer taken while previous item in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_DONE || status == ST_EMPTY || status == ST_FULL))
		else $error("illegal status");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (FW'(fill_count) <= FW'(QUEUE_DEPTH)))
		else $error("fill count beyond depth");

	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DONE |-> out_value == '0 && out_weight == '0)
		else $error("payload not zero on failed operation");

endmodule

bind stable_sorted_priority_queue_top ssq_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_ssq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.out_value  (out_value),
	.out_weight (out_weight),
	.fill_count (fill_count)
);

`default_nettype wire
